// ===== design/stok_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package stok_pkg;

  // scanner modes
  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_NAME,
    MODE_NUMBER,
    MODE_STRING,
    MODE_DEAD
  } mode_t;

  // token kinds
  localparam logic [4:0] KIND_END     = 5'd0;
  localparam logic [4:0] KIND_STRING  = 5'd1;
  localparam logic [4:0] KIND_NAME    = 5'd2;
  localparam logic [4:0] KIND_NUMBER  = 5'd3;
  localparam logic [4:0] KIND_KEY0    = 5'd4;
  localparam logic [4:0] KIND_SINGLE0 = 5'd10;
  localparam logic [4:0] KIND_ERROR   = 5'd24;

  // keywords, first byte in the low byte
  localparam int KW_NUM = 6;
  localparam logic [63:0] KW_TEXT [KW_NUM] = '{
    64'h0000_0000_0074_656C,  // let
    64'h0000_0074_736E_6F63,  // const
    64'h0000_0000_006E_7566,  // fun
    64'h0000_0000_0072_6F66,  // for
    64'h0000_0065_6C69_6877,  // while
    64'h0000_6E72_7574_6572   // return
  };
  localparam logic [3:0] KW_LEN [KW_NUM] = '{4'd3, 4'd5, 4'd3, 4'd3, 4'd5, 4'd6};

  typedef struct packed {
    logic [4:0]  kind;
    logic [15:0] start;
    logic [15:0] length;
  } token_t;

  // all tokens caused by one input word
  typedef struct packed {
    logic [1:0]       cnt;
    token_t [2:0]     tok;
  } bundle_t;

  typedef struct packed {
    logic    push;
    bundle_t data;
  } q_push_t;

  typedef struct packed {
    logic    valid;
    bundle_t data;
  } q_head_t;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_ident_start(input logic [7:0] c);
    return is_letter(c) || c == "_";
  endfunction

  function automatic logic is_ident_part(input logic [7:0] c);
    return is_ident_start(c) || is_digit(c);
  endfunction

  function automatic logic is_line_end(input logic [7:0] c);
    return c == 8'h0A || c == 8'h0D;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0B || c == 8'h0C;
  endfunction

  // kind of a single-char token, KIND_ERROR when the byte is none of them
  function automatic logic [4:0] single_kind(input logic [7:0] c);
    logic [4:0] k;
    case (c)
      8'h2B:   k = KIND_SINGLE0 + 5'd0;   // +
      8'h2D:   k = KIND_SINGLE0 + 5'd1;   // -
      8'h2F:   k = KIND_SINGLE0 + 5'd2;   // /
      8'h2A:   k = KIND_SINGLE0 + 5'd3;   // *
      8'h3B:   k = KIND_SINGLE0 + 5'd4;   // ;
      8'h3D:   k = KIND_SINGLE0 + 5'd5;   // =
      8'h28:   k = KIND_SINGLE0 + 5'd6;   // (
      8'h29:   k = KIND_SINGLE0 + 5'd7;   // )
      8'h5B:   k = KIND_SINGLE0 + 5'd8;   // [
      8'h5D:   k = KIND_SINGLE0 + 5'd9;   // ]
      8'h3E:   k = KIND_SINGLE0 + 5'd10;  // >
      8'h3C:   k = KIND_SINGLE0 + 5'd11;  // <
      8'h7B:   k = KIND_SINGLE0 + 5'd12;  // {
      8'h7D:   k = KIND_SINGLE0 + 5'd13;  // }
      default: k = KIND_ERROR;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

// ===== design/source_tokenizer.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Ports
// in        input      in_valid, in_ready, in_char_code, in_is_final
// out       output     out_valid, out_ready, out_token_kind, out_token_start,
//                      out_token_length, out_run_last
//
// The scanner takes one byte per cycle; the tokens a byte causes (zero to three)
// go into a two-bundle queue and leave one per cycle while out_ready is high, so each
// token takes its own output transfer and the output port sets the sustained rate.
// Bytes that cause no token are not queued. Input stalls only when the queue is full.
// Synchronous reset clears scanner state, queue and serializer.
module source_tokenizer #(
  parameter int OFFSET_BITS   = 16,
  parameter int KEYWORD_CHARS = 6
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_char_code,
  input  wire logic        in_is_final,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [4:0]       out_token_kind,
  output logic [15:0]      out_token_start,
  output logic [15:0]      out_token_length,
  output logic             out_run_last
);
  import stok_pkg::*;

  q_push_t q_push;
  q_head_t q_head;
  logic    full;
  logic    pop;

  assign in_ready = !full;

  stok_front #(
    .OFFSET_BITS  (OFFSET_BITS),
    .KEYWORD_CHARS(KEYWORD_CHARS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (in_valid && in_ready),
    .char_code(in_char_code),
    .is_final (in_is_final),
    .q_push   (q_push)
  );

  stok_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .q_push(q_push),
    .pop   (pop),
    .q_head(q_head),
    .full  (full)
  );

  stok_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_head          (q_head),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_token_kind  (out_token_kind),
    .out_token_start (out_token_start),
    .out_token_length(out_token_length),
    .out_run_last    (out_run_last)
  );

endmodule

`default_nettype wire

// ===== design/stok_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module stok_front #(
  parameter int OFFSET_BITS   = 16,
  parameter int KEYWORD_CHARS = 6
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             accept,
  input  wire logic [7:0]       char_code,
  input  wire logic             is_final,
  output stok_pkg::q_push_t     q_push
);
  import stok_pkg::*;

  localparam int WW = 8 * KEYWORD_CHARS;
  localparam int EW = (OFFSET_BITS > 16) ? OFFSET_BITS : 16;
  localparam logic [OFFSET_BITS-1:0] OFS_MAX = {OFFSET_BITS{1'b1}};

  mode_t                  mode_r, mode_nxt, mode_mid;
  logic [OFFSET_BITS-1:0] pos_r, pos_nxt, pos_inc;
  logic [OFFSET_BITS-1:0] begin_r, begin_nxt, begin_mid;
  logic [15:0]            count_r, count_nxt, count_mid;
  logic [WW-1:0]          window_r, window_nxt, window_mid;
  logic                   a_flush, a_err, b_scan;
  token_t [3:0]           slot;
  logic [3:0]             slot_v;
  bundle_t                bundle;

  function automatic logic [15:0] sat16(input logic [OFFSET_BITS-1:0] v);
    logic [EW-1:0] w;
    w = EW'(v);
    return (w > EW'(16'hFFFF)) ? 16'hFFFF : w[15:0];
  endfunction

  function automatic logic [15:0] count_add(input logic [15:0] cnt);
    return (cnt == 16'hFFFF) ? cnt : cnt + 16'd1;
  endfunction

  function automatic logic [WW-1:0] window_add(input logic [15:0] cnt,
                                               input logic [WW-1:0] win,
                                               input logic [7:0] c);
    logic [WW-1:0] w;
    w = win;
    for (int i = 0; i < KEYWORD_CHARS; i++) begin
      if (cnt == 16'(i)) w[8*i +: 8] = c;
    end
    return w;
  endfunction

  function automatic logic [4:0] pend_kind(input mode_t m, input logic [15:0] cnt,
                                           input logic [WW-1:0] win);
    logic [4:0] k;
    k = KIND_NAME;
    case (m)
      MODE_NAME: begin
        for (int i = 0; i < KW_NUM; i++) begin
          if (cnt == 16'(KW_LEN[i]) && win == KW_TEXT[i][WW-1:0]) k = 5'(KIND_KEY0 + i);
        end
      end
      MODE_NUMBER: k = KIND_NUMBER;
      MODE_STRING: k = KIND_STRING;
      default:     k = KIND_NAME;
    endcase
    return k;
  endfunction

  // next state: pending token first, then fresh scan, then end of text
  always_comb begin
    pos_inc    = (pos_r == OFS_MAX) ? pos_r : pos_r + OFFSET_BITS'(1);
    mode_mid   = mode_r;
    begin_mid  = begin_r;
    count_mid  = count_r;
    window_mid = window_r;
    a_flush    = 1'b0;
    a_err      = 1'b0;
    b_scan     = 1'b0;
    case (mode_r)
      MODE_NAME, MODE_NUMBER: begin
        if ((mode_r == MODE_NAME) ? is_ident_part(char_code) : is_digit(char_code)) begin
          count_mid  = count_add(count_r);
          window_mid = window_add(count_r, window_r, char_code);
        end else begin
          a_flush = 1'b1;
          b_scan  = 1'b1;
        end
      end
      MODE_STRING: begin
        if (char_code == 8'h22) begin
          a_flush  = 1'b1;
          mode_mid = MODE_IDLE;
        end else if (is_line_end(char_code)) begin
          a_err    = 1'b1;
          mode_mid = MODE_DEAD;
        end else begin
          count_mid  = count_add(count_r);
          window_mid = window_add(count_r, window_r, char_code);
        end
      end
      MODE_IDLE: b_scan = 1'b1;
      default:   b_scan = 1'b0;
    endcase
    if (b_scan) begin
      mode_mid = MODE_IDLE;
      if (is_space(char_code) || is_line_end(char_code)) begin
        mode_mid = MODE_IDLE;
      end else if (char_code == 8'h22) begin
        begin_mid  = pos_inc;
        count_mid  = 16'd0;
        window_mid = '0;
        mode_mid   = MODE_STRING;
      end else if (is_ident_part(char_code)) begin
        begin_mid  = pos_r;
        count_mid  = 16'd1;
        window_mid = WW'(char_code);
        mode_mid   = is_digit(char_code) ? MODE_NUMBER : MODE_NAME;
      end else if (single_kind(char_code) == KIND_ERROR) begin
        mode_mid = MODE_DEAD;
      end
    end

    mode_nxt   = mode_mid;
    begin_nxt  = begin_mid;
    count_nxt  = count_mid;
    window_nxt = window_mid;
    pos_nxt    = (mode_r == MODE_DEAD) ? pos_r : pos_inc;
    if (is_final && mode_mid != MODE_DEAD) begin
      mode_nxt   = MODE_IDLE;
      begin_nxt  = '0;
      count_nxt  = 16'd0;
      window_nxt = '0;
      pos_nxt    = '0;
    end
  end

  // tokens of this word in order, then packed into a bundle
  always_comb begin
    logic [1:0] n;
    slot   = '0;
    slot_v = '0;
    if (a_flush) begin
      slot_v[0] = 1'b1;
      slot[0]   = '{kind: pend_kind(mode_r, count_r, window_r),
                    start: sat16(begin_r), length: count_r};
    end else if (a_err) begin
      slot_v[0] = 1'b1;
      slot[0]   = '{kind: KIND_ERROR, start: sat16(pos_r), length: 16'd1};
    end
    if (b_scan && !is_space(char_code) && !is_line_end(char_code)
        && char_code != 8'h22 && !is_ident_part(char_code)) begin
      slot_v[1] = 1'b1;
      slot[1]   = '{kind: single_kind(char_code), start: sat16(pos_r), length: 16'd1};
    end
    if (is_final && mode_mid != MODE_DEAD) begin
      if (mode_mid == MODE_NAME || mode_mid == MODE_NUMBER || mode_mid == MODE_STRING) begin
        slot_v[2] = 1'b1;
        slot[2]   = '{kind: pend_kind(mode_mid, count_mid, window_mid),
                      start: sat16(begin_mid), length: count_mid};
      end
      slot_v[3] = 1'b1;
      slot[3]   = '{kind: KIND_END, start: sat16(pos_inc), length: 16'd0};
    end
    n      = 2'd0;
    bundle = '0;
    for (int i = 0; i < 4; i++) begin
      if (slot_v[i] && n != 2'd3) begin
        bundle.tok[n] = slot[i];
        n             = n + 2'd1;
      end
    end
    bundle.cnt = n;
  end

  assign q_push.push = accept && (bundle.cnt != 2'd0);
  assign q_push.data = bundle;

  // scanner state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_IDLE;
      pos_r    <= '0;
      begin_r  <= '0;
      count_r  <= 16'd0;
      window_r <= '0;
    end else if (accept) begin
      mode_r   <= mode_nxt;
      pos_r    <= pos_nxt;
      begin_r  <= begin_nxt;
      count_r  <= count_nxt;
      window_r <= window_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/stok_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module stok_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire stok_pkg::q_push_t q_push,
  input  wire logic          pop,
  output stok_pkg::q_head_t  q_head,
  output logic               full
);
  import stok_pkg::*;

  bundle_t    mem_r [2];
  logic       wr_r, rd_r;
  logic [1:0] cnt_r, cnt_nxt;

  assign full         = (cnt_r == 2'd2);
  assign q_head.valid = (cnt_r != 2'd0);
  assign q_head.data  = mem_r[rd_r];

  // hold count across simultaneous push and pop
  always_comb begin
    cnt_nxt = cnt_r;
    if (q_push.push && !pop) cnt_nxt = cnt_r + 2'd1;
    else if (!q_push.push && pop) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (q_push.push) wr_r <= ~wr_r;
      if (pop) rd_r <= ~rd_r;
      cnt_r <= cnt_nxt;
    end
  end

  // store bundles
  always_ff @(posedge clk) begin
    if (q_push.push) mem_r[wr_r] <= q_push.data;
  end

endmodule

`default_nettype wire

// ===== design/stok_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module stok_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire stok_pkg::q_head_t q_head,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [4:0]         out_token_kind,
  output logic [15:0]        out_token_start,
  output logic [15:0]        out_token_length,
  output logic               out_run_last
);
  import stok_pkg::*;

  logic [1:0] idx_r, idx_nxt;
  token_t     cur;
  logic       take;

  assign cur              = q_head.data.tok[idx_r];
  assign out_valid        = q_head.valid;
  assign out_token_kind   = cur.kind;
  assign out_token_start  = cur.start;
  assign out_token_length = cur.length;
  assign out_run_last     = (idx_r == q_head.data.cnt - 2'd1);
  assign take             = out_valid && out_ready;
  assign pop              = take && out_run_last;

  // advance through the bundle, drop it after its last token
  always_comb begin
    idx_nxt = idx_r;
    if (pop) idx_nxt = 2'd0;
    else if (take) idx_nxt = idx_r + 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) idx_r <= 2'd0;
    else        idx_r <= idx_nxt;
  end

endmodule

`default_nettype wire
